/* rtl/ulcc_pkg.sv */
// ---------------------------------------------------------------------------
// ulcc_pkg: shared types and mapping functions
// Output word bundle type and the code point case map with UTF-8 re-encoder.
// ---------------------------------------------------------------------------
package ulcc_pkg;

	localparam int unsigned MaxRun = 4;

	localparam logic [20:0] CP_LOWER_A   = 21'h000061;
	localparam logic [20:0] CP_LOWER_Z   = 21'h00007A;
	localparam logic [20:0] CP_UPPER_A   = 21'h000041;
	localparam logic [20:0] CP_UPPER_Z   = 21'h00005A;
	localparam logic [20:0] CP_SHARP_S   = 21'h0000DF;
	localparam logic [20:0] CP_LAT_LO_LO = 21'h0000E0;
	localparam logic [20:0] CP_LAT_LO_HI = 21'h0000FE;
	localparam logic [20:0] CP_DIVIDE    = 21'h0000F7;
	localparam logic [20:0] CP_Y_DIAER   = 21'h0000FF;
	localparam logic [20:0] CP_CAP_Y_DI  = 21'h000178;
	localparam logic [20:0] CP_LAT_UP_LO = 21'h0000C0;
	localparam logic [20:0] CP_LAT_UP_HI = 21'h0000DE;
	localparam logic [20:0] CP_TIMES     = 21'h0000D7;
	localparam logic [20:0] CP_CASE_STEP = 21'h000020;
	localparam logic [20:0] CP_LIM_1B    = 21'h000080;
	localparam logic [20:0] CP_LIM_2B    = 21'h000800;
	localparam logic [20:0] CP_LIM_3B    = 21'h010000;
	localparam logic [20:0] CP_MAX       = 21'h10FFFF;
	localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
	localparam logic [7:0]  BYTE_S       = 8'h53;

	localparam logic MODE_UPPER = 1'b0;
	localparam logic MODE_LOWER = 1'b1;

	typedef struct packed {
		logic [MaxRun-1:0][7:0] bytes;
		logic [2:0]             count;
	} bundle_t;

	function automatic bundle_t encode_cp(input logic [20:0] cp);
		bundle_t r;
		r = '0;
		if (cp < CP_LIM_1B) begin
			r.bytes[0] = cp[7:0];
			r.count    = 3'd1;
		end else if (cp < CP_LIM_2B) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.count    = 3'd2;
		end else if (cp < CP_LIM_3B) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.count    = 3'd3;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.count    = 3'd4;
		end
		return r;
	endfunction

	function automatic bundle_t map_encode(input logic [20:0] cp, input logic mode);
		logic [20:0] m;
		bundle_t     r;
		m = cp;
		if (mode == MODE_UPPER) begin
			if (cp >= CP_LOWER_A && cp <= CP_LOWER_Z)
				m = cp - CP_CASE_STEP;
			else if (cp >= CP_LAT_LO_LO && cp <= CP_LAT_LO_HI && cp != CP_DIVIDE)
				m = cp - CP_CASE_STEP;
			else if (cp == CP_Y_DIAER)
				m = CP_CAP_Y_DI;
		end else begin
			if (cp >= CP_UPPER_A && cp <= CP_UPPER_Z)
				m = cp + CP_CASE_STEP;
			else if (cp >= CP_LAT_UP_LO && cp <= CP_LAT_UP_HI && cp != CP_TIMES)
				m = cp + CP_CASE_STEP;
			else if (cp == CP_CAP_Y_DI)
				m = CP_Y_DIAER;
		end
		r = encode_cp(m);
		// sharp s has no single upper case form
		if (mode == MODE_UPPER && cp == CP_SHARP_S) begin
			r          = '0;
			r.bytes[0] = BYTE_S;
			r.bytes[1] = BYTE_S;
			r.count    = 3'd2;
		end
		return r;
	endfunction

endpackage

/* rtl/utf8_latin1_case_converter.sv */
// ---------------------------------------------------------------------------
// utf8_latin1_case_converter: UTF-8 upper/lower case converter
// Maps ASCII and Latin-1 code points in a UTF-8 byte stream to upper or
// lower case and re-encodes them; malformed input passes through unchanged.
// ---------------------------------------------------------------------------
// One input byte is taken per cycle as long as each byte yields at most one
// output word and the output is not stalled. A byte that completes a code
// point, or that flushes a held sequence, yields up to four words; the single
// output word register holds that run while the next byte with words waits.
// Bytes in the middle of a multi-byte sequence yield no words. The first word
// of a byte's run is offered from the output register, after the byte has
// passed the input register. run_last marks the last word of each byte's run.
// case_mode is written through case_mode_we/case_mode_wdata only while idle;
// the user is bound to this, and the block itself does not enforce it.
module utf8_latin1_case_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       case_mode_we,
	input  logic       case_mode_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic       case_mode_q;
	logic       v_s1;
	logic [7:0] text_byte_s1;
	logic       eot_s1;
	logic       advance;
	logic       load;
	logic       free;
	ulcc_pkg::bundle_t bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			case_mode_q <= ulcc_pkg::MODE_UPPER;
		else if (case_mode_we)
			case_mode_q <= case_mode_wdata;
	end

	// a byte with no output words moves on even while the output register is busy
	assign advance  = v_s1 && ((bundle.count == 3'd0) || free);
	assign load     = advance && (bundle.count != 3'd0);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			text_byte_s1 <= text_byte;
			eot_s1       <= end_of_text;
		end
	end

	ulcc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.case_mode   (case_mode_q),
		.text_byte   (text_byte_s1),
		.end_of_text (eot_s1),
		.commit      (advance),
		.bundle      (bundle)
	);

	ulcc_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle_in (bundle),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.free      (free)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with empty input register");

endmodule

/* rtl/ulcc_decode.sv */
// ---------------------------------------------------------------------------
// ulcc_decode: UTF-8 sequence tracker and case mapper
// Holds the open sequence state and builds the output word bundle for the
// byte in the input register.
// ---------------------------------------------------------------------------
module ulcc_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              case_mode,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	input  logic              commit,
	output ulcc_pkg::bundle_t bundle
);

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_RAW,
		TAIL_MAPPED
	} tail_kind_t;

	logic [20:0] partial_q;
	logic [1:0]  need_q;
	logic [1:0]  held_cnt_q;
	logic [7:0]  held_q [3];

	logic [20:0] partial_d;
	logic [1:0]  need_d;
	logic [1:0]  held_cnt_d;
	logic        held_we;
	logic [1:0]  held_widx;

	logic        is_cont, is_ascii, lead2, lead3, lead4;
	logic [20:0] new_cp;
	logic [20:0] min_cp;
	logic        cp_ok;
	logic [1:0]  flush_cnt;
	tail_kind_t  tail_kind;
	logic [20:0] map_cp;
	ulcc_pkg::bundle_t mapped, tail;
	logic [7:0]  flush_b [ulcc_pkg::MaxRun];
	logic [3:0]  total;

	assign is_cont  = (text_byte[7:6] == 2'b10);
	assign is_ascii = ~text_byte[7];
	assign lead2    = (text_byte >= 8'hC2) && (text_byte <= 8'hDF);
	assign lead3    = (text_byte[7:4] == 4'hE);
	assign lead4    = (text_byte >= 8'hF0) && (text_byte <= 8'hF4);
	assign new_cp   = {partial_q[14:0], text_byte[5:0]};

	always_comb begin
		unique case (held_cnt_q)
			2'd1:    min_cp = ulcc_pkg::CP_LIM_1B;
			2'd2:    min_cp = ulcc_pkg::CP_LIM_2B;
			default: min_cp = ulcc_pkg::CP_LIM_3B;
		endcase
	end

	assign cp_ok = (new_cp >= min_cp) && (new_cp <= ulcc_pkg::CP_MAX) &&
	               !((new_cp >= ulcc_pkg::CP_SURR_LO) && (new_cp <= ulcc_pkg::CP_SURR_HI));

	always_comb begin
		partial_d  = partial_q;
		need_d     = need_q;
		held_cnt_d = held_cnt_q;
		held_we    = 1'b0;
		held_widx  = 2'd0;
		flush_cnt  = 2'd0;
		tail_kind  = TAIL_NONE;
		map_cp     = {13'd0, text_byte};

		if (need_q != 2'd0 && is_cont) begin
			partial_d = new_cp;
			need_d    = need_q - 2'd1;
			if (need_q != 2'd1) begin
				// more continuation words to come: hold this one
				if (held_cnt_q != 2'd3) begin
					held_we    = 1'b1;
					held_widx  = held_cnt_q;
					held_cnt_d = held_cnt_q + 2'd1;
				end
				if (end_of_text) begin
					flush_cnt = held_cnt_q;
					tail_kind = TAIL_RAW;
				end
			end else begin
				if (cp_ok) begin
					tail_kind = TAIL_MAPPED;
					map_cp    = new_cp;
				end else begin
					flush_cnt = held_cnt_q;
					tail_kind = TAIL_RAW;
				end
				partial_d  = '0;
				held_cnt_d = 2'd0;
			end
		end else begin
			// fresh byte; an interrupted sequence first drops the held words out unchanged
			if (need_q != 2'd0)
				flush_cnt = held_cnt_q;
			partial_d  = '0;
			need_d     = 2'd0;
			held_cnt_d = 2'd0;
			if (is_ascii) begin
				tail_kind = TAIL_MAPPED;
			end else if (lead2 || lead3 || lead4) begin
				held_we    = 1'b1;
				held_cnt_d = 2'd1;
				if (lead2) begin
					need_d    = 2'd1;
					partial_d = {16'd0, text_byte[4:0]};
				end else if (lead3) begin
					need_d    = 2'd2;
					partial_d = {17'd0, text_byte[3:0]};
				end else begin
					need_d    = 2'd3;
					partial_d = {18'd0, text_byte[2:0]};
				end
				if (end_of_text)
					tail_kind = TAIL_RAW;
			end else begin
				tail_kind = TAIL_RAW;
			end
		end

		if (end_of_text) begin
			partial_d  = '0;
			need_d     = 2'd0;
			held_cnt_d = 2'd0;
		end
	end

	assign mapped = ulcc_pkg::map_encode(map_cp, case_mode);

	always_comb begin
		tail = '0;
		unique case (tail_kind)
			TAIL_RAW: begin
				tail.bytes[0] = text_byte;
				tail.count    = 3'd1;
			end
			TAIL_MAPPED: tail = mapped;
			default:     tail = '0;
		endcase
	end

	assign flush_b[0] = held_q[0];
	assign flush_b[1] = held_q[1];
	assign flush_b[2] = held_q[2];
	assign flush_b[3] = 8'h00;

	assign total = {2'b00, flush_cnt} + {1'b0, tail.count};

	always_comb begin
		bundle = '0;
		for (int i = 0; i < ulcc_pkg::MaxRun; i++) begin
			if (2'(i) < flush_cnt)
				bundle.bytes[i] = flush_b[i];
			else
				bundle.bytes[i] = tail.bytes[2'(i) - flush_cnt];
		end
		// never more than four words per byte
		bundle.count = (total > 4'd4) ? 3'd4 : total[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q  <= '0;
			need_q     <= '0;
			held_cnt_q <= '0;
		end else if (commit) begin
			partial_q  <= partial_d;
			need_q     <= need_d;
			held_cnt_q <= held_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && held_we)
			held_q[held_widx] <= text_byte;
	end

	a_held_with_open: assert property (@(posedge clk) disable iff (!arst_n)
		(need_q != 2'd0) |-> (held_cnt_q != 2'd0) &&
		({1'b0, held_cnt_q} + {1'b0, need_q} <= 3'd4))
		else $error("held count does not match open sequence");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(need_q == 2'd0) |-> (held_cnt_q == 2'd0))
		else $error("held words left with no open sequence");

endmodule

/* rtl/ulcc_serializer.sv */
// ---------------------------------------------------------------------------
// ulcc_serializer: output word register
// Holds one bundle of up to four words and hands them out one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module ulcc_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ulcc_pkg::bundle_t bundle_in,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic              run_last,
	output logic              free
);

	logic                   v_s2;
	logic [ulcc_pkg::MaxRun-1:0][7:0] bytes_s2;
	logic [2:0]             cnt_s2;
	logic [1:0]             idx_q;
	logic                   last_take;

	assign out_valid = v_s2;
	assign out_byte  = bytes_s2[idx_q];
	assign run_last  = ({1'b0, idx_q} + 3'd1 == cnt_s2);
	assign last_take = v_s2 && out_ready && run_last;
	assign free      = !v_s2 || last_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			v_s2  <= 1'b1;
			idx_q <= '0;
		end else if (last_take) begin
			v_s2  <= 1'b0;
			idx_q <= '0;
		end else if (v_s2 && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= bundle_in.bytes;
			cnt_s2   <= bundle_in.count;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("bundle loaded over words still pending");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (cnt_s2 != 3'd0) && (cnt_s2 <= 3'd4) && ({1'b0, idx_q} < cnt_s2))
		else $error("word index past bundle count");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_ready) |=> v_s2 && $stable(idx_q))
		else $error("output advanced while stalled");

endmodule

/* tb/utf8_latin1_case_converter_tb.sv */
// ---------------------------------------------------------------------------
// utf8_latin1_case_converter_tb: self-checking bench for the case converter
// Feeds UTF-8 byte streams (well-formed text, noise, broken and overlong
// sequences) in both case modes, predicts every output word from its own
// decoder and case map, and checks each word as it leaves the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_latin1_case_converter_tb;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned LongStall  = 300;
	localparam int unsigned DrainGap   = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} utf8_seq_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       case_mode_we = 1'b0;
	logic       case_mode_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	text_item_t  pending_words[$];
	out_word_t   want_words[$];
	logic [7:0]  step_bytes[$];
	text_item_t  next_item;
	out_word_t   next_want;

	// converter state as the bench sees it
	logic        mode_q = ulcc_pkg::MODE_UPPER;
	logic [20:0] dec_cp = '0;
	logic [1:0]  dec_need = '0;
	logic [7:0]  dec_held [3];
	logic [1:0]  dec_held_n = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_input = 1'b0;
	logic        stall_go = 1'b0;
	int unsigned stall_left;
	int unsigned items_taken = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	utf8_latin1_case_converter u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.case_mode_we    (case_mode_we),
		.case_mode_wdata (case_mode_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.text_byte       (text_byte),
		.end_of_text     (end_of_text),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_byte        (out_byte),
		.run_last        (run_last)
	);

	always #5 clk = ~clk;

	function automatic utf8_seq_t utf8_of(input logic [20:0] cp);
		utf8_seq_t s;
		s = '0;
		if (cp < 21'h80) begin
			s.b[0] = cp[7:0];
			s.n    = 3'd1;
		end else if (cp < 21'h800) begin
			s.b[0] = {3'b110, cp[10:6]};
			s.b[1] = {2'b10, cp[5:0]};
			s.n    = 3'd2;
		end else if (cp < 21'h10000) begin
			s.b[0] = {4'b1110, cp[15:12]};
			s.b[1] = {2'b10, cp[11:6]};
			s.b[2] = {2'b10, cp[5:0]};
			s.n    = 3'd3;
		end else begin
			s.b[0] = {5'b11110, cp[20:18]};
			s.b[1] = {2'b10, cp[17:12]};
			s.b[2] = {2'b10, cp[11:6]};
			s.b[3] = {2'b10, cp[5:0]};
			s.n    = 3'd4;
		end
		return s;
	endfunction

	function automatic void emit_byte(input logic [7:0] v);
		if (step_bytes.size() < 4)
			step_bytes.push_back(v);
	endfunction

	function automatic void emit_seq(input utf8_seq_t s);
		int i;
		for (i = 0; i < s.n; i++)
			emit_byte(s.b[i]);
	endfunction

	function automatic void emit_cased(input logic [20:0] cp);
		if (mode_q == ulcc_pkg::MODE_UPPER) begin
			if (cp >= 21'h61 && cp <= 21'h7A)
				emit_seq(utf8_of(cp - 21'd32));
			else if (cp == 21'hDF) begin
				// sharp s widens to two capitals
				emit_byte(8'h53);
				emit_byte(8'h53);
			end else if (cp >= 21'hE0 && cp <= 21'hFE && cp != 21'hF7)
				emit_seq(utf8_of(cp - 21'h20));
			else if (cp == 21'hFF)
				emit_seq(utf8_of(21'h178));
			else
				emit_seq(utf8_of(cp));
		end else begin
			if (cp >= 21'h41 && cp <= 21'h5A)
				emit_seq(utf8_of(cp + 21'd32));
			else if (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7)
				emit_seq(utf8_of(cp + 21'h20));
			else if (cp == 21'h178)
				emit_seq(utf8_of(21'hFF));
			else
				emit_seq(utf8_of(cp));
		end
	endfunction

	function automatic void clear_decoder();
		dec_cp     = '0;
		dec_need   = '0;
		dec_held_n = '0;
	endfunction

	function automatic void flush_held();
		int i;
		for (i = 0; i < dec_held_n; i++)
			emit_byte(dec_held[i]);
		clear_decoder();
	endfunction

	function automatic void open_seq(input logic [7:0] b, input logic [1:0] need,
			input logic [20:0] bits);
		dec_held[0] = b;
		dec_held_n  = 2'd1;
		dec_need    = need;
		dec_cp      = bits;
	endfunction

	function automatic void take_fresh(input logic [7:0] b);
		if (b < 8'h80)
			emit_cased({13'd0, b});
		else if (b >= 8'hC2 && b <= 8'hDF)
			open_seq(b, 2'd1, {16'd0, b[4:0]});
		else if (b >= 8'hE0 && b <= 8'hEF)
			open_seq(b, 2'd2, {17'd0, b[3:0]});
		else if (b >= 8'hF0 && b <= 8'hF4)
			open_seq(b, 2'd3, {18'd0, b[2:0]});
		else
			emit_byte(b);
	endfunction

	// Run one accepted byte through the decoder and queue the words it yields.
	function automatic void convert_byte(input logic [7:0] b, input logic eot);
		logic [20:0] cp;
		logic [20:0] floor_cp;
		logic        ok;
		out_word_t   w;
		int          i;
		step_bytes.delete();
		if (dec_need != 0) begin
			if (b[7:6] == 2'b10) begin
				cp       = {dec_cp[14:0], b[5:0]};
				dec_cp   = cp;
				dec_need = dec_need - 2'd1;
				if (dec_need != 0) begin
					if (dec_held_n < 3) begin
						dec_held[dec_held_n] = b;
						dec_held_n = dec_held_n + 2'd1;
					end
				end else begin
					floor_cp = (dec_held_n == 2'd1) ? 21'h80 :
						(dec_held_n == 2'd2) ? 21'h800 : 21'h10000;
					ok = cp >= floor_cp && cp <= 21'h10FFFF &&
						!(cp >= 21'hD800 && cp <= 21'hDFFF);
					if (ok) begin
						clear_decoder();
						emit_cased(cp);
					end else begin
						// overlong, surrogate or out of range: pass raw bytes
						flush_held();
						emit_byte(b);
					end
				end
			end else begin
				flush_held();
				take_fresh(b);
			end
		end else begin
			take_fresh(b);
		end
		if (eot && dec_held_n != 0)
			flush_held();
		for (i = 0; i < step_bytes.size(); i++) begin
			w.data = step_bytes[i];
			w.last = (i == step_bytes.size() - 1);
			want_words.push_back(w);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t: %s mismatch, got %02h want %02h", $time, what, got, want);
	endtask

	task automatic queue_word(input logic [7:0] b, input logic eot);
		text_item_t t;
		t.data = b;
		t.eot  = eot;
		pending_words.push_back(t);
	endtask

	// Mostly well-formed text with random content, some noise and broken runs.
	task automatic queue_random(input int count);
		int unsigned pick;
		int          k;
		int          i;
		int          cut;
		logic [20:0] cp;
		utf8_seq_t   s;
		k = 0;
		while (k < count) begin
			pick = $urandom_range(99);
			if (pick < 86) begin
				if (pick < 35)
					cp = 21'($urandom_range(127));
				else if (pick < 60)
					cp = 21'($urandom_range(255, 128));
				else if (pick < 65)
					cp = 21'h178;
				else if (pick < 72)
					cp = 21'($urandom_range(21'h7FF, 21'h100));
				else if (pick < 80)
					cp = 21'($urandom_range(21'hFFFF, 21'h800));
				else
					cp = 21'($urandom_range(21'h13FFFF, 21'h10000));
				s = utf8_of(cp);
				for (i = 0; i < s.n; i++)
					queue_word(s.b[i], $urandom_range(24) == 0);
				k += s.n;
			end else if (pick < 93) begin
				queue_word(8'($urandom_range(255)), $urandom_range(24) == 0);
				k++;
			end else if (pick < 97) begin
				// truncated lead, left for the next byte to break or end
				s   = utf8_of(21'($urandom_range(21'h10FFFF, 21'h800)));
				cut = $urandom_range(s.n - 1, 1);
				for (i = 0; i < cut; i++)
					queue_word(s.b[i], 1'b0);
				k += cut;
			end else begin
				// overlong three-byte form
				queue_word(8'hE0, 1'b0);
				queue_word({3'b100, 5'($urandom_range(31))}, 1'b0);
				queue_word({2'b10, 6'($urandom_range(63))}, 1'b0);
				k += 3;
			end
		end
		queue_word(8'h61, 1'b1);
	endtask

	task automatic settle();
		while (pending_words.size() != 0 || in_valid || want_words.size() != 0)
			@(negedge clk);
		repeat (DrainGap) @(negedge clk);
	endtask

	task automatic start_phase(input logic mode, input int unsigned send_pct,
			input int unsigned recv_pct);
		@(posedge clk);
		case_mode_we    <= 1'b1;
		case_mode_wdata <= mode;
		mode_q = mode;
		@(posedge clk);
		case_mode_we <= 1'b0;
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// driver: offer the next pending word, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			text_byte   <= 8'h00;
			end_of_text <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				convert_byte(text_byte, end_of_text);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && !hold_input &&
						$urandom_range(99) >= send_idle_pct) begin
					next_item = pending_words.pop_front();
					in_valid    <= 1'b1;
					text_byte   <= next_item.data;
					end_of_text <= next_item.eot;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_left <= 0;
		else if (stall_go)
			stall_left <= LongStall;
		else if (stall_left != 0)
			stall_left <= stall_left - 1;
	end

	// monitor: check each output word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (want_words.size() == 0) begin
					report_mismatch("unexpected word", out_byte, 8'h00);
				end else begin
					next_want = want_words.pop_front();
					if (out_byte !== next_want.data)
						report_mismatch("out_byte", out_byte, next_want.data);
					if (run_last !== next_want.last)
						report_mismatch("run_last", {7'd0, run_last}, {7'd0, next_want.last});
				end
			end
			out_ready <= stall_left == 0 && !stall_go &&
				$urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned mark;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// upper mode: field extremes and the malformed cases
		start_phase(ulcc_pkg::MODE_UPPER, 0, 0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h7A, 1'b0);
		queue_word(8'hC3, 1'b0);
		queue_word(8'h9F, 1'b0);
		queue_word(8'hC3, 1'b0);
		queue_word(8'hBF, 1'b0);
		queue_word(8'hC3, 1'b0);
		queue_word(8'hB7, 1'b0);
		queue_word(8'h80, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(8'hE2, 1'b0);
		queue_word(8'h41, 1'b0);
		queue_word(8'hED, 1'b0);
		queue_word(8'hA0, 1'b0);
		queue_word(8'h80, 1'b0);
		queue_word(8'hF4, 1'b0);
		queue_word(8'h90, 1'b0);
		queue_word(8'h80, 1'b0);
		queue_word(8'h80, 1'b0);
		queue_word(8'hF0, 1'b0);
		queue_word(8'h9F, 1'b1);
		settle();

		// lower mode: capitals, Y with diaeresis, times sign, overlong
		start_phase(ulcc_pkg::MODE_LOWER, 0, 0);
		queue_word(8'h41, 1'b0);
		queue_word(8'hC5, 1'b0);
		queue_word(8'hB8, 1'b0);
		queue_word(8'hC3, 1'b0);
		queue_word(8'h9E, 1'b0);
		queue_word(8'hC3, 1'b0);
		queue_word(8'h97, 1'b0);
		queue_word(8'hE0, 1'b0);
		queue_word(8'h80, 1'b0);
		queue_word(8'h80, 1'b1);
		settle();

		start_phase(ulcc_pkg::MODE_UPPER, 0, 0);
		queue_random(70);
		settle();

		start_phase(ulcc_pkg::MODE_LOWER, 80, 0);
		queue_random(70);
		settle();

		start_phase(ulcc_pkg::MODE_UPPER, 0, 80);
		queue_random(70);
		settle();

		start_phase(ulcc_pkg::MODE_LOWER, 30, 30);
		queue_random(70);
		settle();

		// back-pressure: long receiver hold-off, then a sender pause to drain
		start_phase(ulcc_pkg::MODE_UPPER, 0, 0);
		queue_random(80);
		stall_go = 1'b1;
		@(negedge clk);
		stall_go = 1'b0;
		mark = items_taken + 40;
		while (items_taken < mark && pending_words.size() != 0)
			@(negedge clk);
		hold_input = 1'b1;
		while (in_valid || want_words.size() != 0)
			@(negedge clk);
		hold_input = 1'b0;
		settle();

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
